// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/psk_pkg.sv -----
// Shared types and constants for the permuted sorted key node.
// No dependencies.
package psk_pkg;

    localparam int SLOTS_DEF      = 15;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int ORDER_BITS     = 64;
    localparam int NIB_W          = 4;
    localparam int POS_W          = 4;
    localparam int STATUS_W       = 3;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_SEARCH  = 2'd1,
        OP_DESCEND = 2'd2,
        OP_SPLIT   = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_MATCH     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_SPLIT     = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_SPLIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic last;
    } stat_t;

    // Physical slot at sorted position pos of an order word.
    function automatic logic [NIB_W-1:0] slot_at(input logic [ORDER_BITS-1:0] ow,
                                                 input logic [POS_W-1:0] pos);
        logic [ORDER_BITS-1:0] sh;
        sh = ow >> ({1'b0, pos, 2'b00} + 7'd4);
        return sh[NIB_W-1:0];
    endfunction

endpackage

// ----- rtl/psk_ctrl.sv -----
// Controller state machine for the permuted sorted key node.
// Depends on psk_pkg.
module psk_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_op,
    input  logic             out_ready,
    input  psk_pkg::stat_t   stat,
    output psk_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             out_valid
);

    psk_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psk_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            psk_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_op == psk_pkg::OP_SPLIT)
                        state_next = psk_pkg::S_SPLIT;
                    else
                        state_next = psk_pkg::S_PROBE;
                end
            end
            psk_pkg::S_PROBE:
            begin
                if (stat.done)
                begin
                    cmd.finish = 1'b1;
                    state_next = psk_pkg::S_RESP;
                end
                else
                    cmd.step = 1'b1;
            end
            psk_pkg::S_SPLIT:
            begin
                cmd.emit   = 1'b1;
                state_next = psk_pkg::S_RESP;
            end
            psk_pkg::S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = stat.last ? psk_pkg::S_IDLE : psk_pkg::S_SPLIT;
            end
            default:
                state_next = psk_pkg::S_IDLE;
        endcase
    end

endmodule

// ----- rtl/psk_datapath.sv -----
// Datapath: slot storage, order word, search bounds and result registers.
// Depends on psk_pkg.
module psk_datapath
#(
    parameter int SLOTS      = psk_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = psk_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = psk_pkg::VALUE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  psk_pkg::cmd_t                 cmd,
    input  logic [1:0]                    in_op,
    input  logic [KEY_BITS-1:0]           in_key,
    input  logic [VALUE_BITS-1:0]         in_value,
    input  logic                          in_link,
    output psk_pkg::stat_t                stat,
    output logic [psk_pkg::STATUS_W-1:0]  status,
    output logic [psk_pkg::NIB_W-1:0]     slot,
    output logic [KEY_BITS-1:0]           key_out,
    output logic [VALUE_BITS-1:0]         value_out,
    output logic                          link_out,
    output logic                          last
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MOVED = SLOTS / 2;
    localparam int KEEP  = SLOTS - MOVED;
    localparam int PW    = psk_pkg::POS_W;
    localparam int OW    = psk_pkg::ORDER_BITS;

    logic [KEY_BITS-1:0]   keys_reg [SLOTS];
    logic [VALUE_BITS-1:0] vals_reg [SLOTS];
    logic [SLOTS-1:0]      links_reg;
    logic [OW-1:0]         order_reg;
    logic [SLOTS-1:0]      free_reg;
    logic [PW-1:0]         lo_reg, hi_reg, sp_reg;
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  link_reg;

    logic [PW-1:0]         cnt, mid, rd_pos, lowest;
    logic [PW:0]           sum;
    logic [3:0]            rd_slot, ins_slot, prev_slot;
    logic [SW-1:0]         rd_idx, ins_idx;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  pred, match, full;
    logic [6:0]            shamt;
    logic [OW-1:0]         omask, order_ins;

    assign cnt  = (order_reg[PW-1:0] > PW'(SLOTS)) ? PW'(SLOTS) : order_reg[PW-1:0];
    assign full = (cnt == PW'(SLOTS));
    assign sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid  = sum[PW:1];

    assign rd_pos  = cmd.step ? mid : (cmd.emit ? sp_reg : lo_reg);
    assign rd_slot = psk_pkg::slot_at(order_reg, rd_pos);
    assign rd_idx  = rd_slot[SW-1:0];
    assign rd_key  = keys_reg[rd_idx];

    assign pred  = (op_reg == psk_pkg::OP_DESCEND) ? (rd_key <= key_reg) : (rd_key < key_reg);
    assign match = (lo_reg < cnt) && (rd_key == key_reg);

    assign prev_slot = psk_pkg::slot_at(order_reg, lo_reg - PW'(1));

    always_comb
    begin
        lowest = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
                lowest = PW'(i);
        end
    end

    assign ins_slot  = (|free_reg) ? lowest : cnt;
    assign ins_idx   = ins_slot[SW-1:0];
    assign shamt     = {1'b0, lo_reg, 2'b00} + 7'd4;
    assign omask     = (OW'(1) << shamt) - OW'(1);
    assign order_ins = ((order_reg & ~omask) << 4) | (OW'(ins_slot) << shamt)
                       | ((order_reg & omask) + OW'(1));

    assign stat.done = (lo_reg == hi_reg);
    assign stat.last = last;

    // Stored entries; links reset to zero, keys and values load on insert.
    always_ff @(posedge clk)
    begin
        if (cmd.finish && op_reg == psk_pkg::OP_INSERT && !match && !full)
        begin
            keys_reg[ins_idx] <= key_reg;
            vals_reg[ins_idx] <= val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            links_reg <= '0;
            order_reg <= '0;
            free_reg  <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            sp_reg    <= '0;
            last      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                lo_reg <= '0;
                hi_reg <= cnt;
                sp_reg <= PW'(KEEP);
            end
            if (cmd.step)
            begin
                if (pred)
                    lo_reg <= mid + PW'(1);
                else
                    hi_reg <= mid;
            end
            if (cmd.finish)
            begin
                last <= 1'b1;
                if (op_reg == psk_pkg::OP_INSERT && !match && !full)
                begin
                    links_reg[ins_idx] <= link_reg;
                    free_reg[ins_idx]  <= 1'b0;
                    order_reg          <= order_ins;
                end
            end
            if (cmd.emit)
            begin
                if (!full)
                    last <= 1'b1;
                else
                begin
                    last             <= (sp_reg == PW'(SLOTS - 1));
                    free_reg[rd_idx] <= 1'b1;
                    sp_reg           <= sp_reg + PW'(1);
                    if (sp_reg == PW'(SLOTS - 1))
                        order_reg <= order_reg - OW'(MOVED);
                end
            end
        end
    end

    // Captured request and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            key_reg  <= in_key;
            val_reg  <= in_value;
            link_reg <= in_link;
        end
        if (cmd.finish)
        begin
            key_out <= '0;
            case (op_reg)
                psk_pkg::OP_INSERT:
                begin
                    if (match)
                    begin
                        status    <= psk_pkg::STS_MATCH;
                        slot      <= rd_slot;
                        value_out <= vals_reg[rd_idx];
                        link_out  <= links_reg[rd_idx];
                    end
                    else if (full)
                    begin
                        status    <= psk_pkg::STS_FULL;
                        slot      <= '0;
                        value_out <= '0;
                        link_out  <= 1'b0;
                    end
                    else
                    begin
                        status    <= psk_pkg::STS_INSERTED;
                        slot      <= ins_slot;
                        value_out <= '0;
                        link_out  <= 1'b0;
                    end
                end
                psk_pkg::OP_SEARCH:
                begin
                    if (match)
                    begin
                        status    <= psk_pkg::STS_FOUND;
                        slot      <= rd_slot;
                        value_out <= vals_reg[rd_idx];
                        link_out  <= links_reg[rd_idx];
                    end
                    else
                    begin
                        status    <= psk_pkg::STS_NOT_FOUND;
                        slot      <= '0;
                        value_out <= '0;
                        link_out  <= 1'b0;
                    end
                end
                psk_pkg::OP_DESCEND:
                begin
                    status    <= psk_pkg::STS_FOUND;
                    slot      <= (lo_reg != '0) ? prev_slot + 4'd1 : 4'd0;
                    value_out <= '0;
                    link_out  <= 1'b0;
                end
                default:
                begin
                    status    <= psk_pkg::STS_SPLIT;
                    slot      <= '0;
                    value_out <= '0;
                    link_out  <= 1'b0;
                end
            endcase
        end
        if (cmd.emit)
        begin
            status <= psk_pkg::STS_SPLIT;
            if (full)
            begin
                slot      <= rd_slot;
                key_out   <= rd_key;
                value_out <= vals_reg[rd_idx];
                link_out  <= links_reg[rd_idx];
            end
            else
            begin
                slot      <= '0;
                key_out   <= '0;
                value_out <= '0;
                link_out  <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/permuted_sorted_key_node.sv -----
// Top level of the permuted sorted key node: stream ports, controller, datapath.
// Depends on psk_pkg, psk_ctrl and psk_datapath.
//
// One border node of a sorted key-slice tree, holding up to SLOTS entries
// (key, value, link flag) in physical slots whose sorted order lives in a
// 64-bit order word (count in the low nibble, slot of the i-th key in nibble
// i+1). One transaction is handled at a time. Insert, search and descend run
// a bound search over the sorted order, one key probe per cycle: the node
// takes the transaction, runs ceil(log2(count+1)) probes (at most 4), then
// resolves and updates, and the result sits in the output register until
// taken. Split of a full node emits SLOTS/2 entries, fence key first, each
// held until taken; a refused split gives one result. The next transaction
// is taken once the last result has gone.
module permuted_sorted_key_node
#(
    parameter int SLOTS      = psk_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = psk_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = psk_pkg::VALUE_BITS_DEF,
    localparam int IN_W  = ((2 + KEY_BITS + VALUE_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((4 + KEY_BITS + VALUE_BITS + 1 + 7) / 8) * 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,   // op, key, value, is_link
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,   // slot, key_out, value_out, link_out
    output logic [psk_pkg::STATUS_W-1:0]   m_tuser,   // status
    output logic                           m_tlast
);

    localparam int K_LO = 2;
    localparam int V_LO = K_LO + KEY_BITS;
    localparam int L_LO = V_LO + VALUE_BITS;
    localparam int OK_LO = 4;
    localparam int OV_LO = OK_LO + KEY_BITS;
    localparam int OL_LO = OV_LO + VALUE_BITS;

    psk_pkg::cmd_t  cmd;
    psk_pkg::stat_t stat;

    logic [3:0]            slot;
    logic [KEY_BITS-1:0]   key_out;
    logic [VALUE_BITS-1:0] value_out;
    logic                  link_out;

    // Sequence probes, result hand-off and split emission.
    psk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tdata[1:0]),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    psk_datapath #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_op     (s_tdata[1:0]),
        .in_key    (s_tdata[K_LO +: KEY_BITS]),
        .in_value  (s_tdata[V_LO +: VALUE_BITS]),
        .in_link   (s_tdata[L_LO]),
        .stat      (stat),
        .status    (m_tuser),
        .slot      (slot),
        .key_out   (key_out),
        .value_out (value_out),
        .link_out  (link_out),
        .last      (m_tlast)
    );

    // Pack the result payload, zero fill to whole bytes.
    always_comb
    begin
        m_tdata                      = '0;
        m_tdata[3:0]                 = slot;
        m_tdata[OK_LO +: KEY_BITS]   = key_out;
        m_tdata[OV_LO +: VALUE_BITS] = value_out;
        m_tdata[OL_LO]               = link_out;
    end

endmodule

// ----- rtl/psk_checker.sv -----
// Port-level checker for the permuted sorted key node, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module psk_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    `CHK_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `CHK_IMPL(a_no_overlap, s_tvalid && s_tready, !m_tvalid)
    `CHK_NEXT(a_end_idle, m_tvalid && m_tready && m_tlast, !m_tvalid)
    `CHK_IMPL(a_status_range, m_tvalid, m_tuser != 3'd6 && m_tuser != 3'd7)

endmodule

bind permuted_sorted_key_node psk_checker u_psk_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for permuted_sorted_key_node: stream stimulus and result checks.
// Depends on psk_pkg and the permuted_sorted_key_node RTL; needs no other file.
`timescale 1ns / 1ps

module tb_top;

    localparam int NODE_SLOTS = 15;
    localparam int MOVED      = NODE_SLOTS / 2;
    localparam int KEEP       = NODE_SLOTS - MOVED;
    localparam int IN_W       = 104;
    localparam int OUT_W      = 104;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [63:0] key;
        logic [31:0] value;
        logic        link;
        logic        last;
    } node_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;    // op[1:0], key[65:2], value[97:66], is_link[98]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // slot[3:0], key_out[67:4], value_out[99:68], link_out[100]
    logic [psk_pkg::STATUS_W-1:0] m_tuser;     // status
    logic m_tlast;

    node_result_t pending_results[$];
    int  errors = 0;
    logic hold_req = 1'b0;

    // Shadow copy of the node contents, updated as each transaction is accepted.
    logic [63:0] ord_word;
    logic [14:0] freed;
    logic [63:0] keys_mem [16];
    logic [31:0] vals_mem [16];
    logic        links_mem[16];
    logic [63:0] key_pool [24];

    permuted_sorted_key_node dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #2 clk = ~clk;

    function automatic int live_count();
        return (ord_word[3:0] > NODE_SLOTS) ? NODE_SLOTS : int'(ord_word[3:0]);
    endfunction

    function automatic logic [3:0] phys_slot(int pos);
        return ord_word[(pos + 1) * 4 +: 4];
    endfunction

    // Binary search over the sorted order; returns position or -1, ins = insert point.
    function automatic int locate(logic [63:0] k, output int ins);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = live_count() - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (keys_mem[phys_slot(mid)] < k) lo = mid + 1;
            else if (keys_mem[phys_slot(mid)] > k) hi = mid - 1;
            else begin
                ins = lo;
                return mid;
            end
        end
        ins = lo;
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [3:0] sl, logic [63:0] k,
                                        logic [31:0] v, logic ln, logic la);
        node_result_t r;
        r.status = st; r.slot = sl; r.key = k; r.value = v; r.link = ln; r.last = la;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted transaction to the shadow node and queue its results.
    function automatic void apply_node_op(psk_pkg::op_t op, logic [63:0] k, logic [31:0] v,
                                          logic ln);
        int cnt;
        int ins;
        int pos;
        int s;
        int first;
        int n;
        int half;
        int sh;
        logic [63:0] mask;
        logic [3:0] child;
        cnt = live_count();
        case (op)
            psk_pkg::OP_INSERT: begin
                pos = locate(k, ins);
                if (pos >= 0) begin
                    s = int'(phys_slot(pos));
                    push_result(psk_pkg::STS_MATCH, 4'(s), '0, vals_mem[s], links_mem[s],
                                1'b1);
                end else if (cnt >= NODE_SLOTS) begin
                    push_result(psk_pkg::STS_FULL, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    if (freed != '0) begin
                        s = 0;
                        while (!freed[s]) s++;
                        freed[s] = 1'b0;
                    end else begin
                        s = cnt;
                    end
                    keys_mem[s] = k; vals_mem[s] = v; links_mem[s] = ln;
                    sh = (ins + 1) * 4;
                    mask = (64'd1 << sh) - 64'd1;
                    ord_word = ((ord_word & ~mask) << 4) | (64'(s) << sh)
                               | ((ord_word & mask) + 64'd1);
                    push_result(psk_pkg::STS_INSERTED, 4'(s), '0, '0, 1'b0, 1'b1);
                end
            end
            psk_pkg::OP_SEARCH: begin
                pos = locate(k, ins);
                if (pos >= 0) begin
                    s = int'(phys_slot(pos));
                    push_result(psk_pkg::STS_FOUND, 4'(s), '0, vals_mem[s], links_mem[s],
                                1'b1);
                end else begin
                    push_result(psk_pkg::STS_NOT_FOUND, '0, '0, '0, 1'b0, 1'b1);
                end
            end
            psk_pkg::OP_DESCEND: begin
                first = 0;
                n = cnt;
                while (n > 0) begin
                    half = n / 2;
                    if (keys_mem[phys_slot(first + half)] <= k) begin
                        first = first + half + 1;
                        n = n - half - 1;
                    end else begin
                        n = half;
                    end
                end
                child = (first != 0) ? phys_slot(first - 1) + 4'd1 : 4'd0;
                push_result(psk_pkg::STS_FOUND, child, '0, '0, 1'b0, 1'b1);
            end
            default: begin
                if (cnt != NODE_SLOTS) begin
                    push_result(psk_pkg::STS_SPLIT, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = KEEP; i < NODE_SLOTS; i++) begin
                        s = int'(phys_slot(i));
                        push_result(psk_pkg::STS_SPLIT, 4'(s), keys_mem[s], vals_mem[s],
                                    links_mem[s], i == NODE_SLOTS - 1);
                        freed[s] = 1'b1;
                    end
                    ord_word = ord_word - 64'(MOVED);
                end
            end
        endcase
    endfunction

    // Mostly zero, often short, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Offer one transaction and hold it until the node takes it.
    task automatic send_item(psk_pkg::op_t op, logic [63:0] k, logic [31:0] v, logic ln);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, ln, v, k, op};
        do @(posedge clk); while (!s_tready);
        apply_node_op(op, k, v, ln);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(psk_pkg::OP_SEARCH, 64'd5, '0, 1'b0);          // empty node: not found
        send_item(psk_pkg::OP_DESCEND, '1, '0, 1'b0);            // empty node: child 0
        send_item(psk_pkg::OP_SPLIT, '0, '0, 1'b0);              // not full: refused
        send_item(psk_pkg::OP_INSERT, 64'd0, '1, 1'b1);          // smallest key
        send_item(psk_pkg::OP_INSERT, '1, 32'd0, 1'b0);          // largest key
        send_item(psk_pkg::OP_INSERT, 64'd0, 32'h1234, 1'b0);    // key match, nothing changes
        send_item(psk_pkg::OP_SEARCH, '1, '0, 1'b0);
        send_item(psk_pkg::OP_DESCEND, 64'h8000_0000_0000_0000, '0, 1'b0);
        for (int i = 1; i <= 13; i++)
            send_item(psk_pkg::OP_INSERT, 64'(i) * 64'h1111_1111_1111_1111 - 64'd7,
                      $urandom, 1'($urandom));
        send_item(psk_pkg::OP_INSERT, 64'd42, 32'hdead_beef, 1'b1); // full node
        send_item(psk_pkg::OP_SPLIT, '0, '0, 1'b0);                 // upper seven out
        send_item(psk_pkg::OP_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h5a5a_a5a5,
                  1'b1);                                            // reuse freed slot
        send_item(psk_pkg::OP_SEARCH, 64'd0, '0, 1'b0);
        send_item(psk_pkg::OP_DESCEND, 64'h7fff_ffff_ffff_ffff, '0, 1'b0);
    endtask

    // Random content shaped so the node keeps filling up and splitting.
    task automatic random_item();
        int r;
        psk_pkg::op_t op;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        if (live_count() == NODE_SLOTS && r < 45) op = psk_pkg::OP_SPLIT;
        else if (r < 55) op = psk_pkg::OP_INSERT;
        else if (r < 72) op = psk_pkg::OP_SEARCH;
        else if (r < 88) op = psk_pkg::OP_DESCEND;
        else op = psk_pkg::OP_SPLIT;
        if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, 23)];
        else k = {$urandom, $urandom};
        send_item(op, k, $urandom, 1'($urandom));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) random_item();
    endtask

    // Stall the receiver long enough that the node blocks its input.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) random_item();
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++) random_item();
        wait_drained();
        for (int i = 0; i < 10; i++) random_item();
    endtask

    // Receiver: random ready, or a long hold-off when asked.
    always @(posedge clk) begin : receiver
        static int hold_left = 0;
        if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
            if (hold_left == 0) hold_req = 1'b0;
        end else begin
            m_tready <= (pick_gap() == 0);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk) begin : result_check
        node_result_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d tdata=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.status || m_tdata[3:0] !== e.slot
                    || m_tdata[67:4] !== e.key || m_tdata[99:68] !== e.value
                    || m_tdata[100] !== e.link || m_tlast !== e.last) begin
                    $display("%0t: mismatch expected st=%0d sl=%0d k=%h v=%h ln=%b la=%b",
                             $time, e.status, e.slot, e.key, e.value, e.link, e.last);
                    $display("%0t:          actual   st=%0d sl=%0d k=%h v=%h ln=%b la=%b",
                             $time, m_tuser, m_tdata[3:0], m_tdata[67:4], m_tdata[99:68],
                             m_tdata[100], m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        ord_word = '0;
        freed = '0;
        for (int i = 0; i < 16; i++) begin
            keys_mem[i] = '0; vals_mem[i] = '0; links_mem[i] = 1'b0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(140);
        test_backpressure();
        test_random(100);
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
